/* src/sinusoidal_pose_generator_top_defines.svh */
// Assertion macros for the sinusoidal pose generator.
// Used by sinusoidal_pose_generator_top; expects clk and rst in scope.
`ifndef SINUSOIDAL_POSE_GENERATOR_TOP_DEFINES_SVH
`define SINUSOIDAL_POSE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define SPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spg check failed");

// next-cycle implication
`define SPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spg check failed");

`endif

/* src/spg_pkg.sv */
// Shared constants and types for the sinusoidal pose generator.
// No dependencies.
package spg_pkg;

  localparam int SINE_TABLE_DEPTH    = 1024;
  localparam int PHASE_FRACTION_BITS = 16;

  localparam int NUM_STG  = 12;
  localparam int LANE_STG = 9;

  typedef logic [LANE_STG-1:0] lane_en_t;

  localparam logic [2:0] REG_CENTER   = 3'd0;
  localparam logic [2:0] REG_BASE     = 3'd1;
  localparam logic [2:0] REG_TAMP     = 3'd2;
  localparam logic [2:0] REG_RAMP     = 3'd3;
  localparam logic [2:0] REG_TRATE    = 3'd4;
  localparam logic [2:0] REG_RRATE    = 3'd5;
  localparam logic [2:0] REG_CPHASE   = 3'd6;
  localparam logic [2:0] REG_START    = 3'd7;

  localparam logic [47:0] RATE_RESET = 48'd281474977;

  localparam logic [31:0] TRANS_OFF [3] = '{32'd0, 32'd478495693, 32'd956991386};
  localparam logic [31:0] ROT_OFF   [3] = '{32'd0, 32'd615208748, 32'd1230417496};

  // Q30 Taylor coefficients of sin(pi/2 x), Horner order
  localparam logic [30:0] COEF0 = 31'd172273;
  localparam logic [30:0] COEF1 = 31'd5026994;
  localparam logic [30:0] COEF2 = 31'd85569306;
  localparam logic [30:0] COEF3 = 31'd693598668;
  localparam logic [30:0] COEF4 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

endpackage

/* src/spg_phase.sv */
// Phase accumulator product: dt * rate mod 2^48, split into 24-bit partials.
// Depends on nothing outside this file.
module spg_phase (
  input  logic        clk,
  input  logic        en_mul,
  input  logic        en_sum,
  input  logic [39:0] dt,
  input  logic [47:0] rate,
  output logic [47:0] phase
);

  logic [47:0] prod_ll;
  logic [23:0] prod_lh;
  logic [23:0] prod_hl;
  logic [47:0] mul_lh;
  logic [39:0] mul_hl;

  assign mul_lh = dt[23:0] * rate[47:24];
  assign mul_hl = dt[39:24] * rate[23:0];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_ll <= dt[23:0] * rate[23:0];
      prod_lh <= mul_lh[23:0];
      prod_hl <= mul_hl[23:0];
    end
    if (en_sum) begin
      phase <= prod_ll + {prod_lh + prod_hl, 24'd0};
    end
  end

endmodule

/* src/spg_lane.sv */
// One output axis: phase to sine by a pipelined polynomial, then scale,
// round, offset and saturate. Uses spg_pkg.
module spg_lane #(
  parameter int KEEP_BITS = 10
) (
  input  logic                   clk,
  input  spg_pkg::lane_en_t      en,
  input  logic [31:0]            phase,
  input  logic signed [15:0]     amp,
  input  logic signed [15:0]     base,
  output logic signed [15:0]     value
);

  localparam logic [31:0] TMASK = ~((32'd1 << (32 - KEEP_BITS)) - 32'd1);

  logic [31:0] t;
  logic [30:0] x_in;
  logic [30:0] x3, x4, x5, x6, x7, x8;
  logic [1:0]  q3, q4, q5, q6, q7, q8, q9;
  logic [61:0] xx4;
  logic [30:0] x2_5, x2_6, x2_7;
  logic [48:0] m5;
  logic [61:0] m6, m7, m8, m9;
  logic [30:0] p6, p7, p8, p9;
  logic [31:0] s_mag;
  logic signed [32:0] s_sgn;
  logic signed [48:0] prod10;
  logic signed [49:0] rnd;
  logic signed [19:0] scaled;
  logic signed [20:0] sum;

  assign t    = phase & TMASK;
  assign x_in = t[30] ? (spg_pkg::Q30_ONE - {1'b0, t[29:0]}) : {1'b0, t[29:0]};

  assign p6 = spg_pkg::COEF1 - {12'd0, m5[48:30]};
  assign p7 = spg_pkg::COEF2 - m6[60:30];
  assign p8 = spg_pkg::COEF3 - m7[60:30];
  assign p9 = spg_pkg::COEF4 - m8[60:30];

  assign s_mag = m9[61:30];
  assign s_sgn = q9[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  assign rnd    = 50'(prod10) + 50'sd536870912;
  assign scaled = 20'(rnd >>> 30);
  assign sum    = 21'(base) + 21'(scaled);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x3 <= x_in;
      q3 <= t[31:30];
    end
    if (en[1]) begin
      xx4 <= x3 * x3;
      x4  <= x3;
      q4  <= q3;
    end
    if (en[2]) begin
      x2_5 <= xx4[60:30];
      m5   <= spg_pkg::COEF0[17:0] * xx4[60:30];
      x5   <= x4;
      q5   <= q4;
    end
    if (en[3]) begin
      m6   <= p6 * x2_5;
      x2_6 <= x2_5;
      x6   <= x5;
      q6   <= q5;
    end
    if (en[4]) begin
      m7   <= p7 * x2_6;
      x2_7 <= x2_6;
      x7   <= x6;
      q7   <= q6;
    end
    if (en[5]) begin
      m8 <= p8 * x2_7;
      x8 <= x7;
      q8 <= q7;
    end
    if (en[6]) begin
      m9 <= p9 * x8;
      q9 <= q8;
    end
    if (en[7]) begin
      prod10 <= amp * s_sgn;
    end
    if (en[8]) begin
      if (sum > 21'sd32767) begin
        value <= 16'sh7fff;
      end else if (sum < -21'sd32768) begin
        value <= -16'sd32768;
      end else begin
        value <= sum[15:0];
      end
    end
  end

endmodule

/* src/sinusoidal_pose_generator_top.sv */
// Top level of the sinusoidal pose generator: register file, elapsed time,
// phase products and six axis lanes. Uses spg_pkg, spg_phase, spg_lane.
//
//   channel  | signals                               | dir
//   time     | time_valid, time_stall, time_now      | in
//   pose     | pose_valid, pose_stall, pos_*, *_angle| out
//   config   | psel, penable, pwrite, paddr, pwdata  | in/out
//
// Twelve register stages; one item per cycle while pose_stall is low.
// Stages advance independently, so bubbles are squeezed out under stall.
// Reset clears valid bits and loads register defaults; no clearing pass.
// time_stall follows pose_stall only once every stage holds an item.
module sinusoidal_pose_generator_top #(
  parameter int SINE_TABLE_DEPTH    = spg_pkg::SINE_TABLE_DEPTH,
  parameter int PHASE_FRACTION_BITS = spg_pkg::PHASE_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               time_valid,
  output logic               time_stall,
  input  logic [39:0]        time_now,
  output logic               pose_valid,
  input  logic               pose_stall,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  `include "sinusoidal_pose_generator_top_defines.svh"

  localparam int LOG_DEPTH = $clog2(SINE_TABLE_DEPTH);
  localparam int KEEP_BITS = (LOG_DEPTH < PHASE_FRACTION_BITS) ? LOG_DEPTH
                                                                : PHASE_FRACTION_BITS;
  localparam int NS = spg_pkg::NUM_STG;

  logic [47:0] center_xyz;
  logic [47:0] base_angles;
  logic [47:0] translation_amplitudes;
  logic [47:0] rotation_amplitudes;
  logic [47:0] translation_rate;
  logic [47:0] rotation_rate;
  logic [15:0] common_phase;
  logic [39:0] start_time;

  logic        wr;
  logic [2:0]  ridx;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [39:0]   dt;
  logic [47:0]   ph_t, ph_r;
  logic signed [15:0] lane_out [6];

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_xyz             <= '0;
      base_angles            <= '0;
      translation_amplitudes <= '0;
      rotation_amplitudes    <= '0;
      translation_rate       <= spg_pkg::RATE_RESET;
      rotation_rate          <= spg_pkg::RATE_RESET;
      common_phase           <= '0;
      start_time             <= '0;
    end else if (wr) begin
      case (ridx)
        spg_pkg::REG_CENTER: center_xyz             <= pwdata[47:0];
        spg_pkg::REG_BASE:   base_angles            <= pwdata[47:0];
        spg_pkg::REG_TAMP:   translation_amplitudes <= pwdata[47:0];
        spg_pkg::REG_RAMP:   rotation_amplitudes    <= pwdata[47:0];
        spg_pkg::REG_TRATE:  translation_rate       <= pwdata[47:0];
        spg_pkg::REG_RRATE:  rotation_rate          <= pwdata[47:0];
        spg_pkg::REG_CPHASE: common_phase           <= pwdata[15:0];
        spg_pkg::REG_START:  start_time             <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      spg_pkg::REG_CENTER: prdata = {16'd0, center_xyz};
      spg_pkg::REG_BASE:   prdata = {16'd0, base_angles};
      spg_pkg::REG_TAMP:   prdata = {16'd0, translation_amplitudes};
      spg_pkg::REG_RAMP:   prdata = {16'd0, rotation_amplitudes};
      spg_pkg::REG_TRATE:  prdata = {16'd0, translation_rate};
      spg_pkg::REG_RRATE:  prdata = {16'd0, rotation_rate};
      spg_pkg::REG_CPHASE: prdata = {48'd0, common_phase};
      spg_pkg::REG_START:  prdata = {24'd0, start_time};
      default:             prdata = '0;
    endcase
  end

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = !vld[NS-1] || !pose_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? time_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign time_stall = !en[0];
  assign pose_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt <= (time_now > start_time) ? time_now - start_time : 40'd0;
    end
  end

  spg_phase u_phase_t (
    .clk    (clk),
    .en_mul (en[1]),
    .en_sum (en[2]),
    .dt     (dt),
    .rate   (translation_rate),
    .phase  (ph_t)
  );

  spg_phase u_phase_r (
    .clk    (clk),
    .en_mul (en[1]),
    .en_sum (en[2]),
    .dt     (dt),
    .rate   (rotation_rate),
    .phase  (ph_r)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [31:0] p_t, p_r;
    assign p_t = ph_t[47:16] + {common_phase, 16'd0} + spg_pkg::TRANS_OFF[i];
    assign p_r = ph_r[47:16] + {common_phase, 16'd0} + spg_pkg::ROT_OFF[i];

    spg_lane #(.KEEP_BITS(KEEP_BITS)) u_pos (
      .clk   (clk),
      .en    (en[NS-1:3]),
      .phase (p_t),
      .amp   (translation_amplitudes[16*i +: 16]),
      .base  (center_xyz[16*i +: 16]),
      .value (lane_out[i])
    );

    spg_lane #(.KEEP_BITS(KEEP_BITS)) u_ang (
      .clk   (clk),
      .en    (en[NS-1:3]),
      .phase (p_r),
      .amp   (rotation_amplitudes[16*i +: 16]),
      .base  (base_angles[16*i +: 16]),
      .value (lane_out[3+i])
    );
  end

  assign pos_x       = lane_out[0];
  assign pos_y       = lane_out[1];
  assign pos_z       = lane_out[2];
  assign roll_angle  = lane_out[3];
  assign pitch_angle = lane_out[4];
  assign yaw_angle   = lane_out[5];

  `SPG_ASSERT_NEXT(a_accept_fills, time_valid && !time_stall, vld[0])
  `SPG_ASSERT_NOW(a_stall_full, time_stall, vld[0] && vld[1])
  `SPG_ASSERT_NEXT(a_out_hold, pose_valid && pose_stall, pose_valid && $stable(pos_x))

endmodule
